FILE: src/solar_hijri_date_stepper_unit_assert.svh
// Assertion macros for the checker file.
`ifndef SOLAR_HIJRI_DATE_STEPPER_UNIT_ASSERT_SVH
`define SOLAR_HIJRI_DATE_STEPPER_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is high
`define SHDS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shds check failed");

// Next-cycle implication, masked while reset is high
`define SHDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shds check failed");

`endif

FILE: src/shds_pkg.sv
package shds_pkg;

   // Operation codes carried in the request tuser
   typedef enum logic [1:0] {
      OP_NEXT = 2'd0,
      OP_PREV = 2'd1,
      OP_LOAD = 2'd2,
      OP_HOLD = 2'd3
   } op_type;

   localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
   localparam logic [3:0]  LAST_LONG_MONTH = 4'd6;
   localparam logic [4:0]  LEN_LONG        = 5'd31;
   localparam logic [4:0]  LEN_SHORT       = 5'd30;
   localparam logic [4:0]  LEN_ESFAND     = 5'd29;
   localparam logic [1:0]  LEAP_PHASE      = 2'd3;
   localparam logic [2:0]  LAST_WEEKDAY    = 3'd6;
   localparam logic [3:0]  WEEK_LEN        = 4'd7;

   localparam logic [11:0] RESET_YEAR    = 12'd1348;
   localparam logic [3:0]  RESET_MONTH   = 4'd10;
   localparam logic [4:0]  RESET_DAY     = 5'd11;
   localparam logic [2:0]  RESET_WEEKDAY = 3'd5;

   // Date plus weekday; packs with year in the low bits
   typedef struct packed {
      logic [2:0]  weekday;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } date_type;

   // One request word after unpacking
   typedef struct packed {
      op_type      op;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } req_type;

   // Days in a month; the last month is long in years with year mod 4 = 3
   function automatic logic [4:0] month_len(input logic [11:0] year,
                                            input logic [3:0] month);
      logic [4:0] len;
      if (month <= LAST_LONG_MONTH) begin
         len = LEN_LONG;
      end else if (month != MONTHS_PER_YEAR || year[1:0] == LEAP_PHASE) begin
         len = LEN_SHORT;
      end else begin
         len = LEN_ESFAND;
      end
      return len;
   endfunction

   // Days of the year before the first of a month
   function automatic logic [8:0] month_offset(input logic [3:0] month);
      logic [8:0] off;
      case (month)
         4'd1:    off = 9'd0;
         4'd2:    off = 9'd31;
         4'd3:    off = 9'd62;
         4'd4:    off = 9'd93;
         4'd5:    off = 9'd124;
         4'd6:    off = 9'd155;
         4'd7:    off = 9'd186;
         4'd8:    off = 9'd216;
         4'd9:    off = 9'd246;
         4'd10:   off = 9'd276;
         4'd11:   off = 9'd306;
         4'd12:   off = 9'd336;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

   // Residue mod 7 by folding octal digits (8 is 1 mod 7)
   function automatic logic [2:0] mod7(input logic [12:0] v);
      logic [4:0] s1;
      logic [3:0] s2;
      logic [3:0] s3;
      s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[11:9]) + 5'(v[12]);
      s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
      s3 = 4'(s2[2:0]) + 4'(s2[3]);
      if (s3 >= WEEK_LEN) begin
         s3 = s3 - WEEK_LEN;
      end
      return s3[2:0];
   endfunction

endpackage

FILE: src/shds_in_stage.sv
module shds_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // load_year[11:0], load_month[15:12], load_day[20:16]
   input  logic [1:0]        req_tuser,   // opcode[1:0]
   input  logic              advance,
   output logic              valid,
   output shds_pkg::req_type req
);

   logic              valid_ff, valid_in;
   shds_pkg::req_type req_ff, req_in;
   logic              take;

   // Accept a word when the register is empty or drains this cycle
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      req_in.op    = shds_pkg::op_type'(req_tuser);
      req_in.year  = req_tdata[11:0];
      req_in.month = req_tdata[15:12];
      req_in.day   = req_tdata[20:16];
      valid_in     = take || (valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_in;
      end
   end

   assign valid = valid_ff;
   assign req   = req_ff;

endmodule

FILE: src/shds_core.sv
module shds_core (
   input  shds_pkg::req_type  req,
   input  shds_pkg::date_type cur,
   output shds_pkg::date_type nxt
);

   logic [4:0]  cur_len;
   logic [4:0]  prev_len;
   logic [3:0]  prev_month;
   logic [11:0] prev_year;
   logic [3:0]  ld_month;
   logic [4:0]  ld_len;
   logic [4:0]  ld_day;
   logic [12:0] ld_sum;

   always_comb begin
      // Length of the current month for the forward step
      cur_len = shds_pkg::month_len(cur.year, cur.month);

      // Month and year that a backward step falls into
      if (cur.month <= 4'd1) begin
         prev_month = shds_pkg::MONTHS_PER_YEAR;
         prev_year  = cur.year - 12'd1;
      end else begin
         prev_month = cur.month - 4'd1;
         prev_year  = cur.year;
      end
      prev_len = shds_pkg::month_len(prev_year, prev_month);

      // Clamp the load fields and compute the weekday
      if (req.month == 4'd0) begin
         ld_month = 4'd1;
      end else if (req.month > shds_pkg::MONTHS_PER_YEAR) begin
         ld_month = shds_pkg::MONTHS_PER_YEAR;
      end else begin
         ld_month = req.month;
      end
      ld_len = shds_pkg::month_len(req.year, ld_month);
      if (req.day == 5'd0) begin
         ld_day = 5'd1;
      end else if (req.day > ld_len) begin
         ld_day = ld_len;
      end else begin
         ld_day = req.day;
      end
      ld_sum = 13'(req.year) + 13'(req.year[11:2]) + 13'(ld_day)
             + 13'(shds_pkg::month_offset(ld_month));

      nxt = cur;
      case (req.op)
         shds_pkg::OP_NEXT: begin
            if (cur.day >= cur_len) begin
               nxt.day = 5'd1;
               if (cur.month >= shds_pkg::MONTHS_PER_YEAR) begin
                  nxt.month = 4'd1;
                  nxt.year  = cur.year + 12'd1;
               end else begin
                  nxt.month = cur.month + 4'd1;
               end
            end else begin
               nxt.day = cur.day + 5'd1;
            end
            nxt.weekday = (cur.weekday == shds_pkg::LAST_WEEKDAY) ? 3'd0
                                                                  : cur.weekday + 3'd1;
         end
         shds_pkg::OP_PREV: begin
            if (cur.day <= 5'd1) begin
               nxt.month = prev_month;
               nxt.year  = prev_year;
               nxt.day   = prev_len;
            end else begin
               nxt.day = cur.day - 5'd1;
            end
            nxt.weekday = (cur.weekday == 3'd0) ? shds_pkg::LAST_WEEKDAY
                                                : cur.weekday - 3'd1;
         end
         shds_pkg::OP_LOAD: begin
            nxt.year    = req.year;
            nxt.month   = ld_month;
            nxt.day     = ld_day;
            nxt.weekday = shds_pkg::mod7(ld_sum);
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

FILE: src/solar_hijri_date_stepper_unit.sv
// Channel  Dir  Payload (low bit first)                          Accept
// req      in   tdata: year[11:0] month[15:12] day[20:16]        tvalid & tready
//               tuser: opcode[1:0]
// rsp      out  tdata: year[11:0] month[15:12] day[20:16]        tvalid & tready
//                      weekday[23:21]
// One word per cycle is taken unless the result stalls.
// The input register feeds one pass of date logic into the result register,
// and the date state updates in that same cycle.
// Reset is synchronous and loads 1348-10-11, weekday 5; both channels empty.
// A stalled result holds; the input register takes one more word while the
// result register waits, then req_tready follows rsp_tready.
module solar_hijri_date_stepper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // load_year[11:0], load_month[15:12], load_day[20:16]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // cur_year[11:0], cur_month[15:12], cur_day[20:16],
                                    // weekday[23:21]
);

   logic               in_valid;
   shds_pkg::req_type  in_req;
   logic               advance;
   shds_pkg::date_type date_ff, date_in;
   shds_pkg::date_type rsp_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   shds_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .valid      (in_valid),
      .req        (in_req)
   );

   shds_core u_core (
      .req (in_req),
      .cur (date_ff),
      .nxt (date_in)
   );

   // Move a word into the result slot when it is free or drains now
   assign advance = in_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Date state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         date_ff.year    <= shds_pkg::RESET_YEAR;
         date_ff.month   <= shds_pkg::RESET_MONTH;
         date_ff.day     <= shds_pkg::RESET_DAY;
         date_ff.weekday <= shds_pkg::RESET_WEEKDAY;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (advance) begin
            date_ff <= date_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= date_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: src/shds_checker.sv
`include "solar_hijri_date_stepper_unit_assert.svh"

module shds_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A stalled result word holds
   `SHDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Weekday stays within the week
   `SHDS_ASSERT_NOW(a_weekday_range, clock, reset, rsp_tvalid, rsp_tdata[23:21] != 3'd7)

   // Month stays within the year
   `SHDS_ASSERT_NOW(a_month_range, clock, reset, rsp_tvalid, rsp_tdata[15:12] != 4'd0 && rsp_tdata[15:12] <= 4'd12)

   // Day of month is never zero
   `SHDS_ASSERT_NOW(a_day_nonzero, clock, reset, rsp_tvalid, rsp_tdata[20:16] != 5'd0)

endmodule

bind solar_hijri_date_stepper_unit shds_checker u_shds_checker (.*);

FILE: sim/solar_hijri_date_stepper_unit_tb.sv
module solar_hijri_date_stepper_unit_tb;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_WORDS    = 1300;
   localparam int REPORT_LIMIT    = 10;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_EVERY_THIRD,
      READY_SPARSE
   } ready_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // load_year[11:0], load_month[15:12], load_day[20:16]
   logic [1:0]  req_tuser  = shds_pkg::OP_NEXT;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;   // cur_year[11:0], cur_month[15:12], cur_day[20:16], weekday[23:21]

   // Predicted calendar state and the dates still owed by the block
   shds_pkg::date_type calendar;
   shds_pkg::date_type pending_dates[$];

   int          op_counts[4];
   int          year_wraps;
   int          words_sent;
   int          dates_checked;
   int          mismatch_count;
   int          input_stall_cycles;
   int          idle_cycles;

   // Sender pacing
   int          burst_left;
   bit          steady_send;

   // Receiver pacing; the test side asks for a hold-off by bumping a counter
   int             hold_off_asked;
   int             hold_off_done;
   int             hold_left;
   int             phase_left;
   ready_mode_type ready_mode;

   solar_hijri_date_stepper_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Length of a month; the last month is long when year mod 4 is 3
   function automatic int days_in_month(logic [11:0] year, int month);
      if (month <= 6) begin
         return int'(shds_pkg::LEN_LONG);
      end
      if (month != 12 || year[1:0] == 2'd3) begin
         return int'(shds_pkg::LEN_SHORT);
      end
      return int'(shds_pkg::LEN_ESFAND);
   endfunction

   // Apply one accepted word to the predicted calendar and queue the date
   function automatic void step_calendar(shds_pkg::op_type op, logic [11:0] year,
                                         logic [3:0] month, logic [4:0] day);
      int mon;
      int dd;
      int len;
      int offset;
      op_counts[op]++;
      case (op)
         shds_pkg::OP_NEXT: begin
            if (int'(calendar.day) + 1 > days_in_month(calendar.year, calendar.month)) begin
               calendar.day = 5'd1;
               if (calendar.month == 4'd12) begin
                  if (calendar.year == 12'hFFF) begin
                     year_wraps++;
                  end
                  calendar.month = 4'd1;
                  calendar.year  = calendar.year + 12'd1;
               end else begin
                  calendar.month = calendar.month + 4'd1;
               end
            end else begin
               calendar.day = calendar.day + 5'd1;
            end
            calendar.weekday = (calendar.weekday == 3'd6) ? 3'd0 : calendar.weekday + 3'd1;
         end
         shds_pkg::OP_PREV: begin
            if (calendar.day <= 5'd1) begin
               if (calendar.month <= 4'd1) begin
                  if (calendar.year == 12'd0) begin
                     year_wraps++;
                  end
                  calendar.month = 4'd12;
                  calendar.year  = calendar.year - 12'd1;
               end else begin
                  calendar.month = calendar.month - 4'd1;
               end
               calendar.day = 5'(days_in_month(calendar.year, calendar.month));
            end else begin
               calendar.day = calendar.day - 5'd1;
            end
            calendar.weekday = (calendar.weekday == 3'd0) ? 3'd6 : calendar.weekday - 3'd1;
         end
         shds_pkg::OP_LOAD: begin
            // Clamp month, then day against the clamped month
            mon = (month < 4'd1) ? 1 : ((month > 4'd12) ? 12 : int'(month));
            len = days_in_month(year, mon);
            dd  = (day < 5'd1) ? 1 : ((int'(day) > len) ? len : int'(day));
            offset = (mon - 1) * 31 - ((mon >= 8) ? mon - 7 : 0);
            calendar.year    = year;
            calendar.month   = 4'(mon);
            calendar.day     = 5'(dd);
            calendar.weekday = 3'((int'(year) + int'(year) / 4 + dd + offset) % 7);
         end
         default: begin
         end
      endcase
      pending_dates.push_back(calendar);
   endfunction

   // Offer one word and hold it until accepted; pause between bursts
   task automatic send_word(shds_pkg::op_type op, logic [11:0] year, logic [3:0] month,
                            logic [4:0] day);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, day, month, year};
      do begin
         @(posedge clock);
      end while (!req_tready);
      step_calendar(op, year, month, day);
      words_sent++;
      if (!steady_send) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
         end
      end
   endtask

   // Receiver: random ready patterns, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         phase_left <= 0;
         ready_mode <= READY_ALWAYS;
      end else if (hold_off_done != hold_off_asked) begin
         hold_off_done <= hold_off_done + 1;
         hold_left     <= HOLD_OFF_CYCLES;
         rsp_tready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
            phase_left <= $urandom_range(10, 60);
         end else begin
            phase_left <= phase_left - 1;
         end
         case (ready_mode)
            READY_ALWAYS:      rsp_tready <= 1'b1;
            READY_RANDOM:      rsp_tready <= ($urandom_range(0, 3) != 0);
            READY_EVERY_THIRD: rsp_tready <= (phase_left % 3 == 0);
            default:           rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // Compare each returned word with the oldest predicted date
   always @(posedge clock) begin : check_dates
      shds_pkg::date_type seen;
      shds_pkg::date_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = shds_pkg::date_type'(rsp_tdata);
         if (pending_dates.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT) begin
               $display("%0t: unexpected word y=%0d m=%0d d=%0d wd=%0d", $realtime,
                        seen.year, seen.month, seen.day, seen.weekday);
            end
            mismatch_count++;
         end else begin
            want = pending_dates.pop_front();
            dates_checked++;
            if (seen.year !== want.year || seen.month !== want.month ||
                seen.day !== want.day || seen.weekday !== want.weekday) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("%0t: date mismatch, expected y=%0d m=%0d d=%0d wd=%0d",
                           $realtime, want.year, want.month, want.day, want.weekday);
                  $display("   got y=%0d m=%0d d=%0d wd=%0d",
                           seen.year, seen.month, seen.day, seen.weekday);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on handshake activity; also count input stalls
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && !req_tready) begin
            input_stall_cycles <= input_stall_cycles + 1;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Reset date, then one step each way
   task automatic test_reset_state();
      send_word(shds_pkg::OP_HOLD, 12'd0, 4'd0, 5'd0);
      send_word(shds_pkg::OP_NEXT, 12'hFFF, 4'hF, 5'h1F);
      send_word(shds_pkg::OP_PREV, 12'd0, 4'd0, 5'd0);
   endtask

   // Out-of-range months and days on load
   task automatic test_load_clamping();
      send_word(shds_pkg::OP_LOAD, 12'd0, 4'd0, 5'd0);
      send_word(shds_pkg::OP_LOAD, 12'd1403, 4'd13, 5'd31);
      send_word(shds_pkg::OP_LOAD, 12'd1402, 4'd14, 5'd31);
      send_word(shds_pkg::OP_LOAD, 12'd2047, 4'd15, 5'd0);
      send_word(shds_pkg::OP_LOAD, 12'd1400, 4'd7, 5'd31);
      send_word(shds_pkg::OP_LOAD, 12'd4095, 4'd6, 5'd31);
   endtask

   // Both year wraps, and the last month's end in both leap phases
   task automatic test_year_wrap();
      send_word(shds_pkg::OP_LOAD, 12'd4095, 4'd12, 5'd31);
      send_word(shds_pkg::OP_NEXT, 12'd0, 4'd0, 5'd0);
      send_word(shds_pkg::OP_PREV, 12'd0, 4'd0, 5'd0);
      send_word(shds_pkg::OP_LOAD, 12'd0, 4'd1, 5'd1);
      send_word(shds_pkg::OP_PREV, 12'd0, 4'd0, 5'd0);
      send_word(shds_pkg::OP_LOAD, 12'd4094, 4'd12, 5'd31);
      send_word(shds_pkg::OP_NEXT, 12'd0, 4'd0, 5'd0);
   endtask

   // Month boundaries between the long, short and last months
   task automatic test_month_ends();
      send_word(shds_pkg::OP_LOAD, 12'd1399, 4'd6, 5'd31);
      send_word(shds_pkg::OP_NEXT, 12'd0, 4'd0, 5'd0);
      send_word(shds_pkg::OP_PREV, 12'd0, 4'd0, 5'd0);
      send_word(shds_pkg::OP_LOAD, 12'd1399, 4'd11, 5'd30);
      send_word(shds_pkg::OP_NEXT, 12'd0, 4'd0, 5'd0);
   endtask

   // Unused opcode leaves the date alone whatever the payload
   task automatic test_unused_opcode();
      send_word(shds_pkg::OP_HOLD, 12'hFFF, 4'hF, 5'h1F);
      send_word(shds_pkg::OP_HOLD, 12'h555, 4'hA, 5'h15);
   endtask

   // Fill the block while the receiver holds off
   task automatic test_backpressure();
      int i;
      steady_send = 1'b1;
      hold_off_asked++;
      for (i = 0; i < 40; i++) begin
         send_word(shds_pkg::op_type'($urandom_range(0, 3)), 12'($urandom), 4'($urandom),
                   5'($urandom));
      end
      steady_send = 1'b0;
   endtask

   // Loads near boundaries followed by walks; the rest is raw noise
   task automatic test_random_walks();
      int               run;
      int               walk;
      int               i;
      logic [11:0]      year;
      shds_pkg::op_type op;
      while (words_sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 4))
               0:       year = 12'd0;
               1:       year = 12'hFFF;
               2:       year = 12'($urandom_range(4092, 4095));
               default: year = 12'($urandom);
            endcase
            send_word(shds_pkg::OP_LOAD, year, 4'($urandom_range(1, 12)),
                      ($urandom_range(0, 1) == 1) ? 5'd1 : 5'($urandom_range(28, 31)));
            walk = $urandom_range(0, 2);
            run  = $urandom_range(1, 40);
            for (i = 0; i < run; i++) begin
               if (walk == 0) begin
                  op = shds_pkg::OP_NEXT;
               end else if (walk == 1) begin
                  op = shds_pkg::OP_PREV;
               end else begin
                  op = ($urandom_range(0, 1) == 1) ? shds_pkg::OP_NEXT : shds_pkg::OP_PREV;
               end
               send_word(op, 12'($urandom), 4'($urandom), 5'($urandom));
            end
         end else begin
            send_word(shds_pkg::op_type'($urandom_range(0, 3)), 12'($urandom), 4'($urandom),
                      5'($urandom));
         end
      end
   endtask

   initial begin
      calendar = '{weekday: shds_pkg::RESET_WEEKDAY, day: shds_pkg::RESET_DAY,
                   month: shds_pkg::RESET_MONTH, year: shds_pkg::RESET_YEAR};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_load_clamping();
      test_year_wrap();
      test_month_ends();
      test_unused_opcode();
      test_backpressure();
      test_random_walks();

      // Drain, then give any stray word time to show up
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("Covered %0d loads, %0d next, %0d prev, %0d unused-opcode words, %0d year wraps.",
               op_counts[shds_pkg::OP_LOAD], op_counts[shds_pkg::OP_NEXT],
               op_counts[shds_pkg::OP_PREV], op_counts[shds_pkg::OP_HOLD], year_wraps);
      $display("Checked %0d dates; input held off by the output for %0d cycles.",
               dates_checked, input_stall_cycles);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/shds_pkg.sv
src/shds_in_stage.sv
src/shds_core.sv
src/solar_hijri_date_stepper_unit.sv
src/shds_checker.sv
sim/solar_hijri_date_stepper_unit_tb.sv
